// ===== hw/rtl/demand_page_fill_planner_top_macros.svh =====
// Assertion macros used by the fill planner controller.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef DEMAND_PAGE_FILL_PLANNER_TOP_MACROS_SVH
`define DEMAND_PAGE_FILL_PLANNER_TOP_MACROS_SVH
`ifndef SYNTH
`define DPFP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define DPFP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DPFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPFP_ASSERT_ALWAYS(lbl, cond, msg)
`define DPFP_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define DPFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dpfp_pkg.sv =====
package dpfp_pkg;

    // Default geometry.
    localparam int PAGE_BYTES_DEF  = 128;
    localparam int FRAME_COUNT_DEF = 256;

    // Fixed field widths.
    localparam int PAGE_W    = 25;
    localparam int FRAME_W   = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int KIND_W    = 2;
    localparam int MEM_W     = 15;
    localparam int IMG_W     = 32;
    localparam int LEN_W     = 8;

    // Fill command kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_CODE = 2'd0,
        KIND_DATA = 2'd1,
        KIND_BSS  = 2'd2,
        KIND_REST = 2'd3
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_BASE   = 3'd0,
        CFG_CODE_LENGTH = 3'd1,
        CFG_CODE_IMAGE  = 3'd2,
        CFG_DATA_BASE   = 3'd3,
        CFG_DATA_LENGTH = 3'd4,
        CFG_DATA_IMAGE  = 3'd5,
        CFG_BSS_BASE    = 3'd6,
        CFG_BSS_LENGTH  = 3'd7
    } t_cfg_index;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic quot;
        logic rem;
        logic base;
        logic match;
        logic size;
        logic advance;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } t_sts;

endpackage

// ===== hw/rtl/dpfp_ctrl.sv =====
`include "demand_page_fill_planner_top_macros.svh"

module dpfp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  dpfp_pkg::t_sts i_sts,
    output dpfp_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_QUOT  = 7'b0000010,
        S_REM   = 7'b0000100,
        S_BASE  = 7'b0001000,
        S_MATCH = 7'b0010000,
        S_SIZE  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state: three setup steps, then match, size and emit for each word.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_QUOT;
            end
            S_QUOT:  n_state = S_REM;
            S_REM:   n_state = S_BASE;
            S_BASE:  n_state = S_MATCH;
            S_MATCH: n_state = S_SIZE;
            S_SIZE:  n_state = S_EMIT;
            S_EMIT: begin
                if (!i_out_stall) n_state = i_sts.last ? S_IDLE : S_MATCH;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Handshakes and datapath commands.
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_EMIT);
    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.quot    = (r_state == S_QUOT);
    assign o_cmd.rem     = (r_state == S_REM);
    assign o_cmd.base    = (r_state == S_BASE);
    assign o_cmd.match   = (r_state == S_MATCH);
    assign o_cmd.size    = (r_state == S_SIZE);
    assign o_cmd.advance = (r_state == S_EMIT) && !i_out_stall;

    `DPFP_ASSERT_ALWAYS(a_busy_while_out, !o_out_valid || o_in_stall, "word shown while idle")
    `DPFP_ASSERT_NEXT(a_load_starts, o_cmd.load, r_state == S_QUOT, "accepted page did not start")
    `DPFP_ASSERT_NEXT(a_more_words, o_cmd.advance && !i_sts.last, r_state == S_MATCH, "walk stopped early")

endmodule

// ===== hw/rtl/dpfp_dp.sv =====
module dpfp_dp #(
    parameter int PAGE_BYTES  = dpfp_pkg::PAGE_BYTES_DEF,
    parameter int FRAME_COUNT = dpfp_pkg::FRAME_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dpfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dpfp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [dpfp_pkg::PAGE_W-1:0]    i_virtual_page,
    input  logic [dpfp_pkg::FRAME_W-1:0]   i_frame,
    input  dpfp_pkg::t_cmd                 i_cmd,
    output dpfp_pkg::t_sts                 o_sts,
    output logic [dpfp_pkg::KIND_W-1:0]    o_kind,
    output logic [dpfp_pkg::MEM_W-1:0]     o_mem_address,
    output logic [dpfp_pkg::IMG_W-1:0]     o_image_address,
    output logic [dpfp_pkg::LEN_W-1:0]     o_chunk_length,
    output logic                           o_last,
    output logic                           o_read_only,
    output logic                           o_page_in
);

    localparam int VW      = dpfp_pkg::PAGE_W + $clog2(PAGE_BYTES);
    localparam int SEG_W   = dpfp_pkg::CFG_W + 1;
    localparam int CW      = (VW > SEG_W) ? VW : SEG_W;
    localparam int OW      = $clog2(PAGE_BYTES + 1);
    localparam int RECIP_SH = 16;
    localparam int RECIP   = (1 << RECIP_SH) / FRAME_COUNT;
    localparam int QP_W    = dpfp_pkg::FRAME_W + RECIP_SH + 1;

    // Configuration registers.
    logic [dpfp_pkg::CFG_W-1:0] r_code_base, r_code_len, r_code_img;
    logic [dpfp_pkg::CFG_W-1:0] r_data_base, r_data_len, r_data_img;
    logic [dpfp_pkg::CFG_W-1:0] r_bss_base, r_bss_len;

    // Per-page setup.
    logic [dpfp_pkg::PAGE_W-1:0]  r_page;
    logic [dpfp_pkg::FRAME_W-1:0] r_frame;
    logic [dpfp_pkg::FRAME_W-1:0] r_q;
    logic [dpfp_pkg::FRAME_W-1:0] r_rem;
    logic [dpfp_pkg::MEM_W-1:0]   r_mem0;
    logic [SEG_W-1:0]             r_code_end, r_data_end, r_bss_end;
    logic                         r_code_on, r_data_on, r_bss_on;
    logic [dpfp_pkg::IMG_W-1:0]   r_code_delta, r_data_delta;

    // Walk state.
    logic [VW-1:0]              r_v;
    logic [OW-1:0]              r_offs;
    logic [OW-1:0]              r_new_offs;
    logic [OW-1:0]              r_size;
    logic [1:0]                 r_cnt;
    logic                       r_ro, r_pin;
    dpfp_pkg::t_kind            r_kind;
    logic [SEG_W-1:0]           r_span;
    logic [dpfp_pkg::IMG_W-1:0] r_img;

    // Output word.
    dpfp_pkg::t_kind              r_o_kind;
    logic [dpfp_pkg::MEM_W-1:0]   r_o_mem;
    logic [dpfp_pkg::IMG_W-1:0]   r_o_img;
    logic [dpfp_pkg::LEN_W-1:0]   r_o_len;
    logic                         r_o_last, r_o_ro, r_o_pin;

    // Setup arithmetic: frame modulo by reciprocal, then page start and frame base.
    logic [QP_W-1:0]  quot_prod;
    logic [VW-1:0]    v_start;
    logic [31:0]      rem_prod, rem_diff, rem_fix;
    logic [31:0]      mem0_full;

    always_comb begin
        quot_prod = QP_W'(r_frame) * QP_W'(RECIP);
        v_start   = VW'(r_page) * VW'(PAGE_BYTES);
        rem_prod  = 32'(r_q) * 32'(FRAME_COUNT);
        rem_diff  = 32'(r_frame) - rem_prod;
        rem_fix   = (rem_diff >= 32'(FRAME_COUNT)) ? rem_diff - 32'(FRAME_COUNT) : rem_diff;
        mem0_full = 32'(r_rem) * 32'(PAGE_BYTES);
    end

    // Segment match at the current address, first hit wins.
    logic [CW-1:0]              v_ext;
    logic                       in_code, in_data, in_bss;
    logic [CW-1:0]              code_diff, data_diff, bss_diff;
    logic [OW-1:0]              rest;
    dpfp_pkg::t_kind            m_kind;
    logic [SEG_W-1:0]           m_span;
    logic [dpfp_pkg::IMG_W-1:0] m_img;

    always_comb begin
        v_ext     = CW'(r_v);
        in_code   = r_code_on && (v_ext >= CW'(r_code_base)) && (v_ext < CW'(r_code_end));
        in_data   = r_data_on && (v_ext >= CW'(r_data_base)) && (v_ext < CW'(r_data_end));
        in_bss    = r_bss_on && (v_ext >= CW'(r_bss_base)) && (v_ext < CW'(r_bss_end));
        code_diff = CW'(r_code_end) - v_ext;
        data_diff = CW'(r_data_end) - v_ext;
        bss_diff  = CW'(r_bss_end) - v_ext;
        rest      = OW'(PAGE_BYTES) - r_offs;
        if (in_code) begin
            m_kind = dpfp_pkg::KIND_CODE;
            m_span = code_diff[SEG_W-1:0];
            m_img  = v_ext[dpfp_pkg::IMG_W-1:0] + r_code_delta;
        end else if (in_data) begin
            m_kind = dpfp_pkg::KIND_DATA;
            m_span = data_diff[SEG_W-1:0];
            m_img  = v_ext[dpfp_pkg::IMG_W-1:0] + r_data_delta;
        end else if (in_bss) begin
            m_kind = dpfp_pkg::KIND_BSS;
            m_span = bss_diff[SEG_W-1:0];
            m_img  = '0;
        end else begin
            m_kind = dpfp_pkg::KIND_REST;
            m_span = SEG_W'(rest);
            m_img  = '0;
        end
    end

    // Chunk size, clipped at the page end, and the flags it leaves behind.
    logic [OW-1:0] size;
    logic [OW-1:0] new_offs;
    logic          last;
    logic          ro_n, pin_n;
    logic [31:0]   offs_ext, size_ext;

    always_comb begin
        size     = (r_span < SEG_W'(rest)) ? r_span[OW-1:0] : rest;
        new_offs = r_offs + size;
        last     = (new_offs == OW'(PAGE_BYTES)) || (r_cnt == 2'd3);
        ro_n     = r_ro || ((r_kind == dpfp_pkg::KIND_CODE) && (size == OW'(PAGE_BYTES)));
        pin_n    = r_pin || (r_kind == dpfp_pkg::KIND_CODE) || (r_kind == dpfp_pkg::KIND_DATA);
        offs_ext = 32'(r_offs);
        size_ext = 32'(size);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_base <= '0;
            r_code_len  <= '0;
            r_code_img  <= '0;
            r_data_base <= '0;
            r_data_len  <= '0;
            r_data_img  <= '0;
            r_bss_base  <= '0;
            r_bss_len   <= '0;
        end else if (i_cfg_we) begin
            case (dpfp_pkg::t_cfg_index'(i_cfg_index))
                dpfp_pkg::CFG_CODE_BASE:   r_code_base <= i_cfg_data;
                dpfp_pkg::CFG_CODE_LENGTH: r_code_len  <= i_cfg_data;
                dpfp_pkg::CFG_CODE_IMAGE:  r_code_img  <= i_cfg_data;
                dpfp_pkg::CFG_DATA_BASE:   r_data_base <= i_cfg_data;
                dpfp_pkg::CFG_DATA_LENGTH: r_data_len  <= i_cfg_data;
                dpfp_pkg::CFG_DATA_IMAGE:  r_data_img  <= i_cfg_data;
                dpfp_pkg::CFG_BSS_BASE:    r_bss_base  <= i_cfg_data;
                dpfp_pkg::CFG_BSS_LENGTH:  r_bss_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Walk control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offs <= '0;
            r_cnt  <= '0;
            r_ro   <= 1'b0;
            r_pin  <= 1'b0;
        end else if (i_cmd.load) begin
            r_offs <= '0;
            r_cnt  <= '0;
            r_ro   <= 1'b0;
            r_pin  <= 1'b0;
        end else if (i_cmd.size) begin
            r_ro   <= ro_n;
            r_pin  <= pin_n;
        end else if (i_cmd.advance) begin
            r_offs <= r_new_offs;
            r_cnt  <= r_cnt + 2'd1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page  <= i_virtual_page;
            r_frame <= i_frame;
        end
        if (i_cmd.quot) begin
            r_q          <= quot_prod[RECIP_SH +: dpfp_pkg::FRAME_W];
            r_v          <= v_start;
            r_code_end   <= SEG_W'(r_code_base) + SEG_W'(r_code_len);
            r_data_end   <= SEG_W'(r_data_base) + SEG_W'(r_data_len);
            r_bss_end    <= SEG_W'(r_bss_base) + SEG_W'(r_bss_len);
            r_code_on    <= (r_code_len != '0);
            r_data_on    <= (r_data_len != '0);
            r_bss_on     <= (r_bss_len != '0);
            r_code_delta <= r_code_img - r_code_base;
            r_data_delta <= r_data_img - r_data_base;
        end
        if (i_cmd.rem) begin
            r_rem <= rem_fix[dpfp_pkg::FRAME_W-1:0];
        end
        if (i_cmd.base) begin
            r_mem0 <= mem0_full[dpfp_pkg::MEM_W-1:0];
        end
        if (i_cmd.match) begin
            r_kind <= m_kind;
            r_span <= m_span;
            r_img  <= m_img;
        end
        if (i_cmd.size) begin
            r_size     <= size;
            r_new_offs <= new_offs;
            r_o_kind   <= r_kind;
            r_o_mem    <= r_mem0 + offs_ext[dpfp_pkg::MEM_W-1:0];
            r_o_img    <= r_img;
            r_o_len    <= size_ext[dpfp_pkg::LEN_W-1:0];
            r_o_last   <= last;
            r_o_ro     <= last && ro_n;
            r_o_pin    <= last && pin_n;
        end
        if (i_cmd.advance) begin
            r_v <= r_v + VW'(r_size);
        end
    end

    assign o_sts.last      = r_o_last;
    assign o_kind          = r_o_kind;
    assign o_mem_address   = r_o_mem;
    assign o_image_address = r_o_img;
    assign o_chunk_length  = r_o_len;
    assign o_last          = r_o_last;
    assign o_read_only     = r_o_ro;
    assign o_page_in       = r_o_pin;

endmodule

// ===== hw/rtl/demand_page_fill_planner_top.sv =====
// Demand page fill planner.
// Input channel (i_in_valid / o_in_stall) takes one word per page fault: the
// virtual page number and the physical frame assigned to it.
// Output channel (o_out_valid / i_out_stall) gives one to four fill commands
// per page, in address order; o_last marks the final one, which also carries
// the read-only and page-in flags.
// The configuration port writes the three segment descriptions with
// i_cfg_we / i_cfg_index / i_cfg_data; write it only while the block is idle.
// After a page is accepted, the setup steps run (quotient, remainder, frame
// base); each command then passes through the match, size and emit states,
// and the next command starts only after the previous one is taken. The
// controller returns to idle after the last command is taken.
// One page is worked on at a time; the shared match and clip logic handles
// one command at a time.
// Reset clears all segment registers to zero (all segments absent) and
// returns the controller to idle.
// While i_out_stall is high the current command is held unchanged and the walk
// waits; the next page is not accepted until the last command has been taken.
module demand_page_fill_planner_top #(
    parameter int PAGE_BYTES  = dpfp_pkg::PAGE_BYTES_DEF,
    parameter int FRAME_COUNT = dpfp_pkg::FRAME_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dpfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dpfp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [dpfp_pkg::PAGE_W-1:0]    i_virtual_page,
    input  logic [dpfp_pkg::FRAME_W-1:0]   i_frame,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [dpfp_pkg::KIND_W-1:0]    o_kind,
    output logic [dpfp_pkg::MEM_W-1:0]     o_mem_address,
    output logic [dpfp_pkg::IMG_W-1:0]     o_image_address,
    output logic [dpfp_pkg::LEN_W-1:0]     o_chunk_length,
    output logic                           o_last,
    output logic                           o_read_only,
    output logic                           o_page_in
);

    dpfp_pkg::t_cmd cmd;
    dpfp_pkg::t_sts sts;

    // Sequencer for setup and the per-command walk.
    dpfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Segment registers, address arithmetic and output word.
    dpfp_dp #(
        .PAGE_BYTES  (PAGE_BYTES),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_virtual_page  (i_virtual_page),
        .i_frame         (i_frame),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_kind          (o_kind),
        .o_mem_address   (o_mem_address),
        .o_image_address (o_image_address),
        .o_chunk_length  (o_chunk_length),
        .o_last          (o_last),
        .o_read_only     (o_read_only),
        .o_page_in       (o_page_in)
    );

endmodule
